// File: rtl/dxt_block_decoder_unit_defines.svh
// assertion macros used by the block decoder top module
`ifndef DXT_BLOCK_DECODER_UNIT_DEFINES_SVH
`define DXT_BLOCK_DECODER_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define DXTBD_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define DXTBD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/dxtbd_pkg.sv
// types, constants and helper functions for the block decoder
package dxtbd_pkg;

    // default image limits
    localparam int MAX_W_DEF = 4096;
    localparam int MAX_H_DEF = 4096;

    // register port
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;
    localparam int DIM_W  = 13;

    // fixed field widths
    localparam int PIXEL_W = 12;
    localparam int CMP_W   = 14;

    // register indexes
    typedef enum logic [1:0] {
        REG_MODE   = 2'd0,
        REG_WIDTH  = 2'd1,
        REG_HEIGHT = 2'd2
    } reg_idx_t;

    // configuration seen by the datapath
    typedef struct packed {
        logic             dxt3;
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
    } cfg_t;

    // one 8-bit color
    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } rgb_t;

    // floor(255*v/31): 8v plus a step count for floor(7v/31)
    function automatic logic [7:0] expand5(input logic [4:0] v);
        logic [7:0] base;
        base = {v, 3'b000};
        return base + 8'(v >= 5'd5) + 8'(v >= 5'd9) + 8'(v >= 5'd14)
            + 8'(v >= 5'd18) + 8'(v >= 5'd23) + 8'(v >= 5'd27) + 8'(v >= 5'd31);
    endfunction

    // floor(255*v/63): 4v plus floor(v/21)
    function automatic logic [7:0] expand6(input logic [5:0] v);
        logic [7:0] base;
        base = {v, 2'b00};
        return base + 8'(v >= 6'd21) + 8'(v >= 6'd42) + 8'(v >= 6'd63);
    endfunction

    // rgb565 endpoint to 8 bits per channel
    function automatic rgb_t expand565(input logic [15:0] c);
        rgb_t e;
        e.r = expand5(c[15:11]);
        e.g = expand6(c[10:5]);
        e.b = expand5(c[4:0]);
        return e;
    endfunction

    // floor(x/3) for x up to 765 by reciprocal multiply
    function automatic logic [7:0] div3(input logic [9:0] x);
        logic [20:0] p;
        p = 21'(x) * 21'd683;
        return p[18:11];
    endfunction

endpackage

// File: rtl/dxtbd_regs.sv
// apb-style configuration registers of the block decoder
module dxtbd_regs
    import dxtbd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_MODE:   cfg_next.dxt3   = pwdata[0];
                REG_WIDTH:  cfg_next.width  = pwdata[DIM_W-1:0];
                REG_HEIGHT: cfg_next.height = pwdata[DIM_W-1:0];
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dxt3   <= 1'b0;
            cfg_reg.width  <= DIM_W'(4);
            cfg_reg.height <= DIM_W'(4);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // read mux
    always_comb
    begin
        case (idx)
            REG_MODE:   prdata = DATA_W'(cfg_reg.dxt3);
            REG_WIDTH:  prdata = DATA_W'(cfg_reg.width);
            REG_HEIGHT: prdata = DATA_W'(cfg_reg.height);
            default:    prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/dxtbd_palette.sv
// four-entry palette from two expanded endpoints
module dxtbd_palette
    import dxtbd_pkg::*;
(
    input  rgb_t ep_a,
    input  rgb_t ep_b,
    input  logic four_color,
    output rgb_t pal [4]
);

    logic [23:0] a_flat;
    logic [23:0] b_flat;
    logic [23:0] t1_flat;
    logic [23:0] t2_flat;
    logic [23:0] mid_flat;

    assign a_flat = ep_a;
    assign b_flat = ep_b;

    // per channel thirds and midpoint
    always_comb
    begin
        logic [9:0] s1;
        logic [9:0] s2;
        logic [8:0] sm;
        for (int k = 0; k < 3; k++)
        begin
            s1 = {1'b0, a_flat[8*k +: 8], 1'b0} + 10'(b_flat[8*k +: 8]);
            s2 = 10'(a_flat[8*k +: 8]) + {1'b0, b_flat[8*k +: 8], 1'b0};
            sm = 9'(a_flat[8*k +: 8]) + 9'(b_flat[8*k +: 8]);
            t1_flat[8*k +: 8]  = div3(s1);
            t2_flat[8*k +: 8]  = div3(s2);
            mid_flat[8*k +: 8] = sm[8:1];
        end
    end

    // thirds for four-color blocks, else midpoint and black
    assign pal[0] = ep_a;
    assign pal[1] = ep_b;
    assign pal[2] = four_color ? rgb_t'(t1_flat) : rgb_t'(mid_flat);
    assign pal[3] = four_color ? rgb_t'(t2_flat) : rgb_t'('0);

endmodule

// File: rtl/dxt_block_decoder_unit.sv
// s3tc dxt1/dxt3 block decoder: one block in, sixteen rgba pixels out
//
//   channel   handshake              payload
//   cfg       psel/penable/pwrite    paddr, pwdata -> prdata (pready tied high)
//   blk       blk_valid/blk_stall    color_a, color_b, index_word, alpha_word
//   pix       pix_valid/pix_stall    red, green, blue, alpha, pixel_x, pixel_y, last flags
//
// the pixel serializer sends one pixel per cycle while pix_stall is low.
// endpoints are expanded at the input register, the palette is built on the move
// into the serializer, so the next block waits in the input register meanwhile.
// a taken block passes the input register, the serializer and the output register before its first pixel leaves.
// reset clears the block position and all valid flags; registers reset to dxt1, 4x4.
// pix_stall holds the output register and, once the input register is full, the block side.
`include "dxt_block_decoder_unit_defines.svh"

module dxt_block_decoder_unit
    import dxtbd_pkg::*;
#(
    parameter int MAX_IMAGE_WIDTH  = MAX_W_DEF,
    parameter int MAX_IMAGE_HEIGHT = MAX_H_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready,
    // block items
    input  logic               blk_valid,
    output logic               blk_stall,
    input  logic [15:0]        color_a,
    input  logic [15:0]        color_b,
    input  logic [31:0]        index_word,
    input  logic [63:0]        alpha_word,
    // pixel items
    output logic               pix_valid,
    input  logic               pix_stall,
    output logic [7:0]         red,
    output logic [7:0]         green,
    output logic [7:0]         blue,
    output logic [7:0]         alpha,
    output logic [PIXEL_W-1:0] pixel_x,
    output logic [PIXEL_W-1:0] pixel_y,
    output logic               last_of_block,
    output logic               last_of_image
);

    localparam int BPR_MAX = (MAX_IMAGE_WIDTH / 4 < 1) ? 1 : MAX_IMAGE_WIDTH / 4;
    localparam int ROW_MAX = (MAX_IMAGE_HEIGHT / 4 < 1) ? 1 : MAX_IMAGE_HEIGHT / 4;
    localparam int COL_W   = (BPR_MAX > 1) ? $clog2(BPR_MAX) : 1;
    localparam int ROW_W   = (ROW_MAX > 1) ? $clog2(ROW_MAX) : 1;

    cfg_t cfg;

    dxtbd_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // handshake control
    logic blk_accept;
    logic hold_move;
    logic out_load;
    logic act_done;

    // block position
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    logic [CMP_W-1:0] bpr;
    logic [CMP_W-1:0] rows;
    logic [CMP_W-1:0] bpr_raw;
    logic [CMP_W-1:0] rows_raw;
    logic             row_end;
    logic             img_end;

    // input register
    logic             hold_valid_reg;
    logic             hold_valid_next;
    rgb_t             hold_ea_reg;
    rgb_t             hold_eb_reg;
    logic             hold_four_reg;
    logic             hold_dxt3_reg;
    logic [31:0]      hold_idx_reg;
    logic [63:0]      hold_alp_reg;
    logic [COL_W-1:0] hold_col_reg;
    logic [ROW_W-1:0] hold_row_reg;
    logic             hold_end_reg;

    // serializer
    logic             act_valid_reg;
    logic             act_valid_next;
    logic [3:0]       pix_cnt_reg;
    logic [3:0]       pix_cnt_next;
    rgb_t             act_pal_reg [4];
    rgb_t             pal_new [4];
    logic             act_dxt3_reg;
    logic [31:0]      act_idx_reg;
    logic [63:0]      act_alp_reg;
    logic [COL_W-1:0] act_col_reg;
    logic [ROW_W-1:0] act_row_reg;
    logic             act_end_reg;

    // output register
    logic               pix_valid_reg;
    logic               pix_valid_next;
    rgb_t               rgb_reg;
    logic [7:0]         alpha_reg;
    logic [PIXEL_W-1:0] x_reg;
    logic [PIXEL_W-1:0] y_reg;
    logic               last_block_reg;
    logic               last_image_reg;

    assign out_load   = act_valid_reg && (!pix_valid_reg || !pix_stall);
    assign act_done   = out_load && (pix_cnt_reg == 4'd15);
    assign hold_move  = hold_valid_reg && (!act_valid_reg || act_done);
    assign blk_stall  = hold_valid_reg && !hold_move;
    assign blk_accept = blk_valid && !blk_stall;

    // blocks per row and block rows, saturated to the supported range
    assign bpr_raw  = CMP_W'(cfg.width[DIM_W-1:2]);
    assign rows_raw = CMP_W'(cfg.height[DIM_W-1:2]);

    always_comb
    begin
        if (bpr_raw == '0)
            bpr = CMP_W'(1);
        else if (bpr_raw > CMP_W'(BPR_MAX))
            bpr = CMP_W'(BPR_MAX);
        else
            bpr = bpr_raw;

        if (rows_raw == '0)
            rows = CMP_W'(1);
        else if (rows_raw > CMP_W'(ROW_MAX))
            rows = CMP_W'(ROW_MAX);
        else
            rows = rows_raw;
    end

    assign row_end = (CMP_W'(col_reg) + CMP_W'(1)) >= bpr;
    assign img_end = row_end && ((CMP_W'(row_reg) + CMP_W'(1)) >= rows);

    // raster advance per accepted block
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (blk_accept)
        begin
            if (row_end)
            begin
                col_next = '0;
                row_next = img_end ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    // valid flags and counter
    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (blk_accept)
            hold_valid_next = 1'b1;
        else if (hold_move)
            hold_valid_next = 1'b0;

        act_valid_next = act_valid_reg;
        if (hold_move)
            act_valid_next = 1'b1;
        else if (act_done)
            act_valid_next = 1'b0;

        pix_cnt_next = pix_cnt_reg;
        if (hold_move)
            pix_cnt_next = '0;
        else if (out_load)
            pix_cnt_next = pix_cnt_reg + 4'd1;

        pix_valid_next = pix_valid_reg;
        if (out_load)
            pix_valid_next = 1'b1;
        else if (!pix_stall)
            pix_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg        <= '0;
            row_reg        <= '0;
            hold_valid_reg <= 1'b0;
            act_valid_reg  <= 1'b0;
            pix_cnt_reg    <= '0;
            pix_valid_reg  <= 1'b0;
        end
        else
        begin
            col_reg        <= col_next;
            row_reg        <= row_next;
            hold_valid_reg <= hold_valid_next;
            act_valid_reg  <= act_valid_next;
            pix_cnt_reg    <= pix_cnt_next;
            pix_valid_reg  <= pix_valid_next;
        end
    end

    // input register: expanded endpoints and block position
    always_ff @(posedge clk)
    begin
        if (blk_accept)
        begin
            hold_ea_reg   <= expand565(color_a);
            hold_eb_reg   <= expand565(color_b);
            hold_four_reg <= (color_a > color_b) || cfg.dxt3;
            hold_dxt3_reg <= cfg.dxt3;
            hold_idx_reg  <= index_word;
            hold_alp_reg  <= alpha_word;
            hold_col_reg  <= col_reg;
            hold_row_reg  <= row_reg;
            hold_end_reg  <= img_end;
        end
    end

    dxtbd_palette u_palette (
        .ep_a       (hold_ea_reg),
        .ep_b       (hold_eb_reg),
        .four_color (hold_four_reg),
        .pal        (pal_new)
    );

    // serializer load
    always_ff @(posedge clk)
    begin
        if (hold_move)
        begin
            for (int k = 0; k < 4; k++)
            begin
                act_pal_reg[k] <= pal_new[k];
            end
            act_dxt3_reg <= hold_dxt3_reg;
            act_idx_reg  <= hold_idx_reg;
            act_alp_reg  <= hold_alp_reg;
            act_col_reg  <= hold_col_reg;
            act_row_reg  <= hold_row_reg;
            act_end_reg  <= hold_end_reg;
        end
    end

    // per pixel selection
    logic [1:0]       sel;
    logic [3:0]       nib;
    logic [COL_W+1:0] x_full;
    logic [ROW_W+1:0] y_full;

    assign sel    = act_idx_reg[{pix_cnt_reg, 1'b0} +: 2];
    assign nib    = act_alp_reg[{pix_cnt_reg, 2'b00} +: 4];
    assign x_full = {act_col_reg, pix_cnt_reg[1:0]};
    assign y_full = {act_row_reg, pix_cnt_reg[3:2]};

    // output register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            rgb_reg        <= act_pal_reg[sel];
            alpha_reg      <= act_dxt3_reg ? {nib, nib} : 8'hFF;
            x_reg          <= PIXEL_W'(x_full);
            y_reg          <= PIXEL_W'(y_full);
            last_block_reg <= (pix_cnt_reg == 4'd15);
            last_image_reg <= (pix_cnt_reg == 4'd15) && act_end_reg;
        end
    end

    assign pix_valid     = pix_valid_reg;
    assign red           = rgb_reg.r;
    assign green         = rgb_reg.g;
    assign blue          = rgb_reg.b;
    assign alpha         = alpha_reg;
    assign pixel_x       = x_reg;
    assign pixel_y       = y_reg;
    assign last_of_block = last_block_reg;
    assign last_of_image = last_image_reg;

    // checks
    `DXTBD_ASSERT(a_cnt_parked, !act_valid_reg, pix_cnt_reg == 4'd0, "pixel count not parked")
    `DXTBD_ASSERT(a_last_corner, pix_valid_reg && last_block_reg, x_reg[1:0] == 2'b11 && y_reg[1:0] == 2'b11, "last pixel not at block corner")
    `DXTBD_ASSERT(a_image_in_block, pix_valid_reg && last_image_reg, last_block_reg, "image end off block end")
    `DXTBD_ASSERT_NEXT(a_load_start, hold_move, act_valid_reg && pix_cnt_reg == 4'd0, "serializer did not start")
    `DXTBD_ASSERT_NEXT(a_hold_filled, blk_accept, hold_valid_reg, "accepted item not held")

endmodule
